@@ rtl/h2r_pkg.sv @@
`default_nettype none

package h2r_pkg;

    // Default number of fraction bits; 1 << FRAC_BITS stands for 1.0
    localparam int FRAC_BITS_DEFAULT = 15;

    // Width of every pixel field on the ports
    localparam int FIELD_W = 16;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    // Register stages in each part and in total (start to done)
    localparam int LEVELS_DEPTH  = 3;
    localparam int CHANNEL_DEPTH = 3;
    localparam int LATENCY       = LEVELS_DEPTH + CHANNEL_DEPTH;

    typedef struct packed {
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } rgb_t;

    // Segment of the channel curve picked by the offset hue
    typedef enum logic [1:0] {
        PIECE_RISE,
        PIECE_HIGH,
        PIECE_FALL,
        PIECE_LOW
    } piece_t;

endpackage

`default_nettype wire

@@ rtl/h2r_levels.sv @@
`default_nettype none

// Input conditioning, helper level and per-channel offset hue.
// Three register stages: clamp, multiply, level offset / hue wrap.
module h2r_levels #(
    parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire h2r_pkg::hsl_t         hsl,
    output logic                       out_valid,
    output logic [FRAC_BITS:0]         l_out,
    output logic [FRAC_BITS:0]         d_out,
    output logic [FRAC_BITS+1:0]       t3_red,
    output logic [FRAC_BITS+1:0]       t3_green,
    output logic [FRAC_BITS+1:0]       t3_blue
);

    localparam int VW = FRAC_BITS + 1;
    localparam int EW = (FRAC_BITS + 1 > h2r_pkg::FIELD_W) ? FRAC_BITS + 1 : h2r_pkg::FIELD_W;
    localparam int TW = FRAC_BITS + 2;
    localparam int SW = TW + 1;
    localparam int PW = 2 * VW;

    localparam logic [EW-1:0] ONE_E   = EW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] ONE_V   = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HALF_V  = VW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] ROUND_P = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [SW-1:0] ONE_S   = SW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] TWO_S   = SW'(2) << FRAC_BITS;
    localparam logic [SW-1:0] FULL_S  = SW'(3) << FRAC_BITS;

    // ---- stage 1: clamp, hue mod one ----
    logic [EW-1:0]        hue_ext;
    logic [EW-1:0]        sat_ext;
    logic [EW-1:0]        lit_ext;
    logic [FRAC_BITS-1:0] h1_next;
    logic [VW-1:0]        s1_next;
    logic [VW-1:0]        l1_next;
    logic                 low1_next;

    logic                 v1_reg;
    logic [FRAC_BITS-1:0] h1_reg;
    logic [VW-1:0]        s1_reg;
    logic [VW-1:0]        l1_reg;
    logic                 low1_reg;

    always_comb
    begin
        hue_ext   = EW'(hsl.hue);
        sat_ext   = EW'(hsl.saturation);
        lit_ext   = EW'(hsl.lightness);
        h1_next   = hue_ext[FRAC_BITS-1:0];
        s1_next   = (sat_ext > ONE_E) ? ONE_V : sat_ext[VW-1:0];
        l1_next   = (lit_ext > ONE_E) ? ONE_V : lit_ext[VW-1:0];
        low1_next = (l1_next < HALF_V);
    end

    // ---- stage 2: l*s, 3*hue ----
    logic [PW-1:0] prod2_next;
    logic [TW-1:0] h3_2_next;

    logic          v2_reg;
    logic [PW-1:0] prod2_reg;
    logic [TW-1:0] h3_2_reg;
    logic [VW-1:0] s2_reg;
    logic [VW-1:0] l2_reg;
    logic          low2_reg;

    always_comb
    begin
        prod2_next = PW'(s1_reg) * PW'(l1_reg);
        h3_2_next  = TW'({h1_reg, 1'b0}) + TW'(h1_reg);
    end

    // ---- stage 3: d = hi - l, offset hues wrapped into [0, 3*one) ----
    logic [PW-1:0] prod_up;
    logic [VW-1:0] d3_next;
    logic [SW-1:0] sum_r;
    logic [SW-1:0] sum_b;
    logic [SW-1:0] wrap_r;
    logic [SW-1:0] wrap_b;

    logic          v3_reg;
    logic [VW-1:0] d3_reg;
    logic [VW-1:0] l3_reg;
    logic [TW-1:0] tr3_reg;
    logic [TW-1:0] tg3_reg;
    logic [TW-1:0] tb3_reg;

    always_comb
    begin
        prod_up = prod2_reg + ROUND_P;
        // upper half: hi = l + s - ceil(l*s); lower half: hi = l + floor(l*s)
        if (low2_reg)
        begin
            d3_next = prod2_reg[FRAC_BITS +: VW];
        end
        else
        begin
            d3_next = s2_reg - prod_up[FRAC_BITS +: VW];
        end
        sum_r  = SW'(h3_2_reg) + ONE_S;
        sum_b  = SW'(h3_2_reg) + TWO_S;
        wrap_r = (sum_r >= FULL_S) ? sum_r - FULL_S : sum_r;
        wrap_b = (sum_b >= FULL_S) ? sum_b - FULL_S : sum_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h1_reg    <= h1_next;
        s1_reg    <= s1_next;
        l1_reg    <= l1_next;
        low1_reg  <= low1_next;
        prod2_reg <= prod2_next;
        h3_2_reg  <= h3_2_next;
        s2_reg    <= s1_reg;
        l2_reg    <= l1_reg;
        low2_reg  <= low1_reg;
        d3_reg    <= d3_next;
        l3_reg    <= l2_reg;
        tr3_reg   <= wrap_r[TW-1:0];
        tg3_reg   <= h3_2_reg;
        tb3_reg   <= wrap_b[TW-1:0];
    end

    assign out_valid = v3_reg;
    assign l_out     = l3_reg;
    assign d_out     = d3_reg;
    assign t3_red    = tr3_reg;
    assign t3_green  = tg3_reg;
    assign t3_blue   = tb3_reg;

endmodule

`default_nettype wire

@@ rtl/h2r_channel.sv @@
`default_nettype none

// One color channel: piece select, ramp multiply, final add and saturate.
// Three register stages.
module h2r_channel #(
    parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [FRAC_BITS:0]             l_in,
    input  wire logic [FRAC_BITS:0]             d_in,
    input  wire logic [FRAC_BITS+1:0]           t3,
    output logic                                out_valid,
    output logic [h2r_pkg::FIELD_W-1:0]         level
);

    localparam int VW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 2;
    localparam int PW = 2 * VW;
    localparam int XW = (VW + 1 > h2r_pkg::FIELD_W + 1) ? VW + 1 : h2r_pkg::FIELD_W + 1;

    localparam logic [TW-1:0] HALF_T      = TW'(1) << (FRAC_BITS - 1);
    localparam logic [TW-1:0] THREEHALF_T = TW'(3) << (FRAC_BITS - 1);
    localparam logic [TW-1:0] TWO_T       = TW'(1) << (FRAC_BITS + 1);
    localparam logic [XW-1:0] ONE_X       = XW'(1) << FRAC_BITS;
    localparam logic [XW-1:0] FMAX_X      = XW'(h2r_pkg::FIELD_MAX);

    // ---- stage 1: levels and piece ----
    logic [VW:0]           hi_sum;
    logic [VW:0]           lo_dif;
    logic [TW-1:0]         fall_dist;
    h2r_pkg::piece_t       piece1_next;
    logic [VW-1:0]         factor1_next;

    logic                  v1_reg;
    h2r_pkg::piece_t       piece1_reg;
    logic [VW-1:0]         factor1_reg;
    logic [VW-1:0]         span1_reg;
    logic [VW-1:0]         hi1_reg;
    logic [VW-1:0]         lo1_reg;

    always_comb
    begin
        hi_sum    = (VW + 1)'(l_in) + (VW + 1)'(d_in);
        lo_dif    = (VW + 1)'(l_in) - (VW + 1)'(d_in);
        fall_dist = TWO_T - t3;
        priority if (t3 < HALF_T)
        begin
            piece1_next  = h2r_pkg::PIECE_RISE;
            factor1_next = VW'({t3, 1'b0});
        end
        else if (t3 < THREEHALF_T)
        begin
            piece1_next  = h2r_pkg::PIECE_HIGH;
            factor1_next = '0;
        end
        else if (t3 < TWO_T)
        begin
            piece1_next  = h2r_pkg::PIECE_FALL;
            factor1_next = VW'({fall_dist, 1'b0});
        end
        else
        begin
            piece1_next  = h2r_pkg::PIECE_LOW;
            factor1_next = '0;
        end
    end

    // ---- stage 2: ramp = span * factor, floored ----
    logic [PW-1:0]         prod2;
    logic                  v2_reg;
    h2r_pkg::piece_t       piece2_reg;
    logic [VW-1:0]         ramp2_reg;
    logic [VW-1:0]         hi2_reg;
    logic [VW-1:0]         lo2_reg;

    assign prod2 = PW'(span1_reg) * PW'(factor1_reg);

    // ---- stage 3: pick, add, saturate ----
    logic [VW:0]                   pick;
    logic [XW-1:0]                 pick_x;
    logic [XW-1:0]                 sat_x;
    logic                          v3_reg;
    logic [h2r_pkg::FIELD_W-1:0]   level3_reg;

    always_comb
    begin
        unique case (piece2_reg)
            h2r_pkg::PIECE_RISE,
            h2r_pkg::PIECE_FALL: pick = (VW + 1)'(lo2_reg) + (VW + 1)'(ramp2_reg);
            h2r_pkg::PIECE_HIGH: pick = (VW + 1)'(hi2_reg);
            h2r_pkg::PIECE_LOW:  pick = (VW + 1)'(lo2_reg);
            default:             pick = (VW + 1)'(lo2_reg);
        endcase
        pick_x = XW'(pick);
        sat_x  = (pick_x > ONE_X) ? ONE_X : pick_x;
        if (sat_x > FMAX_X)
        begin
            sat_x = FMAX_X;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        piece1_reg  <= piece1_next;
        factor1_reg <= factor1_next;
        span1_reg   <= {d_in[VW-2:0], 1'b0};
        hi1_reg     <= hi_sum[VW-1:0];
        lo1_reg     <= lo_dif[VW-1:0];
        piece2_reg  <= piece1_reg;
        ramp2_reg   <= prod2[FRAC_BITS +: VW];
        hi2_reg     <= hi1_reg;
        lo2_reg     <= lo1_reg;
        level3_reg  <= sat_x[h2r_pkg::FIELD_W-1:0];
    end

    assign out_valid = v3_reg;
    assign level     = level3_reg;

endmodule

`default_nettype wire

@@ rtl/hsl_to_rgb_convert_unit.sv @@
`default_nettype none

// Channel   | Ports                    | Transaction
// ----------+--------------------------+--------------------------------------
// pixel in  | start, busy, hsl         | taken at a clock edge with start & !busy
// color out | done, rgb                | rgb valid for the one cycle done is high
//
// Fully pipelined: one pixel can enter every cycle, busy is always low.
// Latency runs from the accepting edge to the done cycle through three
// stages in h2r_levels (clamp, l*s multiply, level offset and hue wrap) and
// three in each h2r_channel (piece select, ramp multiply, add and saturate).
// Throughput is one pixel per clock.
// Reset clears only the valid bits; payload registers are not reset.
// There is no output backpressure, so nothing ever stalls.
module hsl_to_rgb_convert_unit #(
    parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire h2r_pkg::hsl_t  hsl,
    output logic                done,
    output h2r_pkg::rgb_t       rgb
);

    localparam int LAT = h2r_pkg::LATENCY;

    // Helper levels shared by all three channels, and one offset hue per channel
    logic                   lv_valid;
    logic [FRAC_BITS:0]     lv_l;
    logic [FRAC_BITS:0]     lv_d;
    logic [FRAC_BITS+1:0]   lv_t3_red;
    logic [FRAC_BITS+1:0]   lv_t3_green;
    logic [FRAC_BITS+1:0]   lv_t3_blue;

    // Per-channel results; the three valid flags march in lockstep
    logic                          red_valid;
    logic                          green_valid;
    logic                          blue_valid;
    logic [h2r_pkg::FIELD_W-1:0]   red_level;
    logic [h2r_pkg::FIELD_W-1:0]   green_level;
    logic [h2r_pkg::FIELD_W-1:0]   blue_level;

    // Never stalls: every start is taken
    assign busy = 1'b0;

    h2r_levels #(
        .FRAC_BITS (FRAC_BITS)
    ) u_levels (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .hsl       (hsl),
        .out_valid (lv_valid),
        .l_out     (lv_l),
        .d_out     (lv_d),
        .t3_red    (lv_t3_red),
        .t3_green  (lv_t3_green),
        .t3_blue   (lv_t3_blue)
    );

    // Red sees hue + 1/3 turn, green the hue, blue hue - 1/3 turn
    h2r_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lv_valid),
        .l_in      (lv_l),
        .d_in      (lv_d),
        .t3        (lv_t3_red),
        .out_valid (red_valid),
        .level     (red_level)
    );

    h2r_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lv_valid),
        .l_in      (lv_l),
        .d_in      (lv_d),
        .t3        (lv_t3_green),
        .out_valid (green_valid),
        .level     (green_level)
    );

    h2r_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lv_valid),
        .l_in      (lv_l),
        .d_in      (lv_d),
        .t3        (lv_t3_blue),
        .out_valid (blue_valid),
        .level     (blue_level)
    );

    assign done      = red_valid;
    assign rgb.red   = red_level;
    assign rgb.green = green_level;
    assign rgb.blue  = blue_level;

    // The three channel pipelines must stay aligned
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (red_valid == green_valid) && (green_valid == blue_valid))
        else $error("channel valid flags out of step");

    // Every accepted pixel comes out on done once it has passed the whole pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result missing at expected latency");

    // No result without a matching start
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result with no matching transaction");

    // Zero saturation gives grey
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (hsl.saturation == '0)) |->
            ##LAT ((rgb.red == rgb.green) && (rgb.green == rgb.blue)))
        else $error("zero saturation did not give grey");

endmodule

`default_nettype wire
